// ===== hdl/mwo_pkg.sv =====
// Shared types and constants of the morphing wavetable oscillator.
package mwo_pkg;

  localparam int IndexBitsDefault  = 9;
  localparam int SampleBitsDefault = 12;
  localparam int FracBits          = 16;
  localparam int FastShift         = 3;
  localparam int PhaseBits         = 32;
  localparam logic [15:0] MorphMax = 16'hFFFF;

  // Beat kind carried in tuser
  typedef enum logic [1:0] {
    OP_RENDER  = 2'd0,
    OP_WRITE_A = 2'd1,
    OP_WRITE_B = 2'd2
  } op_t;

  // Render sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_READ,
    ST_X0,
    ST_X1,
    ST_Y
  } state_t;

endpackage

// ===== hdl/morphing_wavetable_oscillator_unit.sv =====
// Morphing wavetable oscillator: two tables, crossfade by morph, interpolate by phase fraction.
//
// Input beats carry their kind in s_tuser: a table write (A or B) stores one entry and is
// taken while the sequencer is idle; a write beyond the last entry and the unused kind are dropped.
// A render beat advances the 32-bit phase by time_base * pitch_cv (x8 in fast rate mode,
// phase cleared first on restart), crossfades both tables at entries i and i+1 by the
// saturated morph amount, then interpolates the two by the 16-bit phase fraction. A render
// runs through acceptance, increment, registered table read, two crossfades and the
// interpolation in turn, since one shared signed multiplier does all four products; it
// waits at the interpolation only while the previous result is still held on the master
// side. New beats are taken once the sequencer is back at idle, even with a result
// still waiting. Tables are not cleared at reset and must be written before they are used.
module morphing_wavetable_oscillator_unit #(
  parameter int INDEX_BITS  = mwo_pkg::IndexBitsDefault,
  parameter int SAMPLE_BITS = mwo_pkg::SampleBitsDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // table_index[9:0], table_value[21:10], time_base[33:22], pitch_cv[45:34],
  // rate_mode[46], restart[47], morph_base[67:48], morph_cv[79:68]
  input  logic [79:0]                          s_tdata,
  // opcode[1:0]
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // sample[SAMPLE_BITS-1:0], zero padded
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  import mwo_pkg::*;

  localparam int TableDepth = (1 << INDEX_BITS) + 1;
  localparam int AddrW      = INDEX_BITS + 1;
  localparam int OutW       = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int MulAW      = (SAMPLE_BITS + 1 > 13) ? SAMPLE_BITS + 1 : 13;
  localparam int MulBW      = FracBits + 1;
  localparam int ProdW      = MulAW + MulBW;
  localparam int FracLsb    = PhaseBits - INDEX_BITS - FracBits;

  // Input beat fields
  logic [9:0]  in_index;
  logic [11:0] in_value;
  logic [11:0] in_time_base;
  logic [11:0] in_pitch_cv;
  logic        in_rate_mode;
  logic        in_restart;
  logic [19:0] in_morph_base;
  logic [11:0] in_morph_cv;

  assign in_index      = s_tdata[9:0];
  assign in_value      = s_tdata[21:10];
  assign in_time_base  = s_tdata[33:22];
  assign in_pitch_cv   = s_tdata[45:34];
  assign in_rate_mode  = s_tdata[46];
  assign in_restart    = s_tdata[47];
  assign in_morph_base = s_tdata[67:48];
  assign in_morph_cv   = s_tdata[79:68];

  state_t state;
  state_t state_next;

  logic accept;
  logic render_go;
  logic write_a;
  logic write_b;
  logic index_ok;
  logic out_free;

  // Render operands held for the sequence
  logic [11:0] time_base;
  logic [11:0] pitch_cv;
  logic        rate_mode;
  logic        restart;
  logic [15:0] morph;
  logic [20:0] morph_sum;

  logic [PhaseBits-1:0] phase;
  logic [PhaseBits-1:0] inc;

  // Tables and their read registers
  logic [SAMPLE_BITS-1:0] table_a [TableDepth];
  logic [SAMPLE_BITS-1:0] table_b [TableDepth];
  logic [SAMPLE_BITS-1:0] a0, a1, b0, b1;
  logic [SAMPLE_BITS-1:0] x0, x1;
  logic [SAMPLE_BITS-1:0] wr_value;
  logic [AddrW-1:0]       wr_addr;
  logic [AddrW-1:0]       rd_addr0;
  logic [AddrW-1:0]       rd_addr1;
  logic [FracBits-1:0]    frac;

  // Shared multiplier
  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS-1:0]      blend_from;
  logic signed [MulAW-1:0]     mul_a;
  logic signed [MulBW-1:0]     mul_b;
  logic signed [ProdW-1:0]     prod;
  logic [SAMPLE_BITS-1:0]      blend_out;

  // Control from the output decoder
  logic sel_inc;
  logic do_read;
  logic load_x0;
  logic load_x1;
  logic load_y;

  assign accept    = s_tvalid && s_tready;
  assign render_go = accept && (s_tuser == OP_RENDER);
  assign index_ok  = 32'(in_index) < 32'(TableDepth);
  assign write_a   = accept && (s_tuser == OP_WRITE_A) && index_ok;
  assign write_b   = accept && (s_tuser == OP_WRITE_B) && index_ok;
  assign out_free  = !m_tvalid || m_tready;
  assign morph_sum = 21'(in_morph_base) + 21'(in_morph_cv);
  assign wr_addr   = AddrW'(in_index);
  assign wr_value  = SAMPLE_BITS'(in_value);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (render_go) state_next = ST_INC;
      ST_INC:  state_next = ST_READ;
      ST_READ: state_next = ST_X0;
      ST_X0:   state_next = ST_X1;
      ST_X1:   state_next = ST_Y;
      ST_Y:    if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    sel_inc  = 1'b0;
    do_read  = 1'b0;
    load_x0  = 1'b0;
    load_x1  = 1'b0;
    load_y   = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_INC:  sel_inc  = 1'b1;
      ST_READ: do_read  = 1'b1;
      ST_X0:   load_x0  = 1'b1;
      ST_X1:   load_x1  = 1'b1;
      ST_Y:    load_y   = out_free;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch render operands, saturate morph
  always_ff @(posedge clk) begin
    if (render_go) begin
      time_base <= in_time_base;
      pitch_cv  <= in_pitch_cv;
      rate_mode <= in_rate_mode;
      restart   <= in_restart;
      morph     <= (morph_sum > 21'(MorphMax)) ? MorphMax : morph_sum[15:0];
    end
  end

  // Select multiplier operands and the blend origin for this step
  always_comb begin
    diff       = '0;
    blend_from = '0;
    mul_a      = MulAW'(signed'({1'b0, time_base}));
    mul_b      = MulBW'(signed'({1'b0, pitch_cv}));
    if (load_x0) begin
      diff       = signed'({1'b0, b0}) - signed'({1'b0, a0});
      blend_from = a0;
      mul_a      = MulAW'(diff);
      mul_b      = signed'({1'b0, morph});
    end else if (load_x1) begin
      diff       = signed'({1'b0, b1}) - signed'({1'b0, a1});
      blend_from = a1;
      mul_a      = MulAW'(diff);
      mul_b      = signed'({1'b0, morph});
    end else if (state == ST_Y) begin
      diff       = signed'({1'b0, x1}) - signed'({1'b0, x0});
      blend_from = x0;
      mul_a      = MulAW'(diff);
      mul_b      = signed'({1'b0, frac});
    end
  end

  assign prod = mul_a * mul_b;
  // Floor of prod / 2^16 keeps its low bits from bit 16 up
  assign blend_out = blend_from + prod[SAMPLE_BITS + FracBits - 1:FracBits];

  // Advance the phase accumulator
  always_comb begin
    inc = PhaseBits'(prod[23:0]);
    if (rate_mode) inc = inc << FastShift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (sel_inc) begin
      phase <= (restart ? '0 : phase) + inc;
    end
  end

  assign rd_addr0 = {1'b0, phase[PhaseBits-1 -: INDEX_BITS]};
  assign rd_addr1 = rd_addr0 + AddrW'(1);
  assign frac     = phase[FracLsb +: FracBits];

  // Table A: write on accept, read both neighbours
  always_ff @(posedge clk) begin
    if (write_a) table_a[wr_addr] <= wr_value;
    if (do_read) begin
      a0 <= table_a[rd_addr0];
      a1 <= table_a[rd_addr1];
    end
  end

  // Table B: write on accept, read both neighbours
  always_ff @(posedge clk) begin
    if (write_b) table_b[wr_addr] <= wr_value;
    if (do_read) begin
      b0 <= table_b[rd_addr0];
      b1 <= table_b[rd_addr1];
    end
  end

  // Hold crossfaded entries
  always_ff @(posedge clk) begin
    if (load_x0) x0 <= blend_out;
    if (load_x1) x1 <= blend_out;
  end

  // Output register: hold the sample until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_y) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_y) m_tdata <= OutW'(blend_out);
  end

`ifndef SYNTH
  a_render_starts: assert property (@(posedge clk) disable iff (rst)
    render_go |=> state == ST_INC)
    else $error("render beat did not start the sequence");

  a_sequence_runs: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_X0 ##1 state == ST_X1 ##1 state == ST_Y)
    else $error("render sequence broke off");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Y && !out_free) |=> (state == ST_Y && m_tvalid))
    else $error("result lost while output held");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Y && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished render gave no result");
`endif

endmodule

// ===== dv/morphing_wavetable_oscillator_unit_tb.sv =====
// Self-checking testbench for the morphing wavetable oscillator unit.
module morphing_wavetable_oscillator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mwo_pkg::*;

  localparam int IndexBits   = IndexBitsDefault;
  localparam int SampleBits  = SampleBitsDefault;
  localparam int TableLast   = 1 << IndexBits;
  localparam int OutWidth    = ((SampleBits + 7) / 8) * 8;
  localparam int RandomItems = 720;
  localparam int DrainCycles = 32;
  localparam int CycleLimit  = 600000;
  localparam int MorphBaseTop = 1048320;
  localparam logic [1:0] OpUnused = 2'd3;

  // s_tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [11:0] morph_cv;
    logic [19:0] morph_base;
    logic        restart;
    logic        rate_mode;
    logic [11:0] pitch_cv;
    logic [11:0] time_base;
    logic [11:0] table_value;
    logic [9:0]  table_index;
  } osc_beat_t;

  // Receiver back-pressure styles
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_style_t;

  // Tracks tables and phase, predicts each rendered sample
  class osc_sample_board;
    logic [SampleBits-1:0] wave_a [0:TableLast];
    logic [SampleBits-1:0] wave_b [0:TableLast];
    logic [PhaseBits-1:0]  phase;
    logic [SampleBits-1:0] pending_samples [$];
    int                    errors;

    function new();
      phase  = '0;
      errors = 0;
    endfunction

    // from + floor((to - from) * w / 2^16)
    function logic [SampleBits-1:0] crossfade(logic [SampleBits-1:0] from,
                                              logic [SampleBits-1:0] to,
                                              logic [15:0] w);
      longint prod;
      prod = (longint'(to) - longint'(from)) * longint'(w);
      return SampleBits'(longint'(from) + (prod >>> FracBits));
    endfunction

    function void note_beat(logic [1:0] opcode, osc_beat_t beat);
      logic [PhaseBits-1:0]  step;
      logic [20:0]           morph_sum;
      logic [15:0]           morph;
      logic [IndexBits:0]    idx;
      logic [FracBits-1:0]   frac;
      logic [SampleBits-1:0] x0;
      logic [SampleBits-1:0] x1;
      case (opcode)
        OP_WRITE_A: begin
          if (beat.table_index <= TableLast)
            wave_a[beat.table_index] = beat.table_value[SampleBits-1:0];
        end
        OP_WRITE_B: begin
          if (beat.table_index <= TableLast)
            wave_b[beat.table_index] = beat.table_value[SampleBits-1:0];
        end
        OP_RENDER: begin
          step = PhaseBits'(beat.time_base) * PhaseBits'(beat.pitch_cv);
          if (beat.rate_mode)
            step = step << FastShift;
          morph_sum = 21'(beat.morph_base) + 21'(beat.morph_cv);
          morph = (morph_sum > 21'(MorphMax)) ? MorphMax : morph_sum[15:0];
          if (beat.restart)
            phase = '0;
          phase = phase + step;
          idx  = (IndexBits + 1)'(phase >> (PhaseBits - IndexBits));
          frac = phase[PhaseBits-IndexBits-1 -: FracBits];
          x0 = crossfade(wave_a[idx], wave_b[idx], morph);
          x1 = crossfade(wave_a[idx + 1'b1], wave_b[idx + 1'b1], morph);
          pending_samples.push_back(crossfade(x0, x1, frac));
        end
        default: ;
      endcase
    endfunction

    function void check_sample(logic [SampleBits-1:0] got);
      logic [SampleBits-1:0] want;
      if (pending_samples.size() == 0) begin
        $error("sample: no result expected, got 0x%03h", got);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) begin
          $error("sample: expected 0x%03h, got 0x%03h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  osc_beat_t           s_tdata = '0;
  logic [1:0]          s_tuser = OP_RENDER;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;

  osc_sample_board sb = new();
  int              burst_left = 0;
  int              cycle_count = 0;
  int              ready_count = 0;
  ready_style_t    ready_style = READY_ALWAYS;

  morphing_wavetable_oscillator_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Score accepted beats on both sides; check before noting
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_sample(m_tdata[SampleBits-1:0]);
    if (!rst && s_tvalid && s_tready)
      sb.note_beat(s_tuser, s_tdata);
  end

  // Receiver stalls, switching style each time the low eight bits of ready_count wrap to zero
  always @(posedge clk) begin
    ready_count <= ready_count + 1;
    if (ready_count[7:0] == 8'd0)
      ready_style <= ready_style_t'($urandom_range(0, 3));
    case (ready_style)
      READY_ALWAYS:   m_tready <= 1'b1;
      READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
      default:        m_tready <= (ready_count[3:1] != 3'b111);
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("morphing_wavetable_oscillator_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic osc_beat_t random_beat();
    osc_beat_t beat;
    beat.table_index = 10'($urandom_range(0, TableLast));
    beat.table_value = 12'($urandom_range(0, 4095));
    beat.time_base   = 12'($urandom_range(0, 4095));
    beat.pitch_cv    = 12'($urandom_range(0, 4095));
    beat.rate_mode   = 1'($urandom_range(0, 1));
    beat.restart     = ($urandom_range(0, 15) == 0);
    beat.morph_base  = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, MorphBaseTop))
                                                   : 20'($urandom_range(0, 61440));
    beat.morph_cv    = 12'($urandom_range(0, 4095));
    return beat;
  endfunction

  // Present one beat in bursts with random gaps; hold valid within a burst
  task automatic send_beat(input logic [1:0] op, input osc_beat_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_entry(input logic [1:0] op, input int index, input int value);
    osc_beat_t beat;
    beat = random_beat();
    beat.table_index = 10'(index);
    beat.table_value = 12'(value);
    send_beat(op, beat);
  endtask

  task automatic render(input int tb, input int cv, input bit fast, input bit restart,
                        input int mbase, input int mcv);
    osc_beat_t beat;
    beat = random_beat();
    beat.time_base  = 12'(tb);
    beat.pitch_cv   = 12'(cv);
    beat.rate_mode  = fast;
    beat.restart    = restart;
    beat.morph_base = 20'(mbase);
    beat.morph_cv   = 12'(mcv);
    send_beat(OP_RENDER, beat);
  endtask

  initial begin
    int        done_items;
    int        pick;
    osc_beat_t beat;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load both tables fully; put the extremes at both ends, B below A at the top
    for (int i = 0; i <= TableLast; i++) begin
      if (i == 0) begin
        write_entry(OP_WRITE_A, i, 0);
        write_entry(OP_WRITE_B, i, 4095);
      end else if (i == 1 || i == TableLast) begin
        write_entry(OP_WRITE_A, i, 4095);
        write_entry(OP_WRITE_B, i, 0);
      end else begin
        write_entry(OP_WRITE_A, i, $urandom_range(0, 4095));
        write_entry(OP_WRITE_B, i, $urandom_range(0, 4095));
      end
    end

    // Dropped beats: writes past the last entry and the unused opcode
    write_entry(OP_WRITE_A, TableLast + 1, 0);
    write_entry(OP_WRITE_B, 1023, 4095);
    beat = '1;
    send_beat(OpUnused, beat);

    // Directed renders: zero step, saturated morph, exact full morph, fastest step
    render(0, 0, 1'b0, 1'b1, 0, 0);
    render(0, 4095, 1'b1, 1'b1, MorphBaseTop, 4095);
    render(4095, 4095, 1'b1, 1'b0, 61440, 4095);
    render(4095, 4095, 1'b1, 1'b0, 32768, 0);
    render(4095, 4095, 1'b0, 1'b0, 65535, 0);
    render(1, 1, 1'b0, 1'b0, 255, 1);
    render(4095, 1, 1'b0, 1'b1, 65536, 0);
    render(2048, 4095, 1'b1, 1'b0, 0, 4095);
    render(4095, 2048, 1'b1, 1'b0, 12345, 2222);
    write_entry(OP_WRITE_A, TableLast, 0);
    write_entry(OP_WRITE_B, TableLast, 4095);
    render(4095, 4095, 1'b1, 1'b0, 40000, 100);

    // Random mix: mostly renders, some table rewrites, a little noise
    done_items = 0;
    while (done_items < RandomItems) begin
      beat = random_beat();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_beat(OP_RENDER, beat);
        done_items++;
      end else if (pick < 95) begin
        send_beat((pick[0]) ? OP_WRITE_A : OP_WRITE_B, beat);
        done_items++;
      end else if (pick < 98) begin
        beat.table_index = 10'($urandom_range(TableLast + 1, 1023));
        send_beat((pick[0]) ? OP_WRITE_A : OP_WRITE_B, beat);
      end else begin
        send_beat(OpUnused, beat);
      end
    end
    s_tvalid <= 1'b0;

    // Drain
    while (sb.pending_samples.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0 && sb.pending_samples.size() == 0)
      $display("morphing_wavetable_oscillator_unit_tb: done, clean");
    else
      $display("morphing_wavetable_oscillator_unit_tb: done, errors");
    $finish;
  end

endmodule
